@@ rtl/lrast_pkg.sv @@
`timescale 1ns / 1ps
package lrast_pkg;

    localparam int unsigned LEAVES = 1024;
    localparam int unsigned LW = 10;
    localparam int unsigned AW = LW + 1;
    localparam int unsigned IW = LW + 2;
    localparam int unsigned JW = 4;
    localparam int unsigned DW = 32;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUM = 2'd1;
    localparam logic [1:0] OP_LOWER = 2'd2;
    localparam logic [1:0] OP_UPPER = 2'd3;

    typedef struct packed {
        logic [1:0]           operation;
        logic [AW-1:0]        range_left;
        logic [AW-1:0]        range_right;
        logic signed [DW-1:0] add_value;
        logic [LW-1:0]        start_pos;
        logic signed [DW-1:0] threshold;
    } lrast_in_t;

    typedef struct packed {
        logic signed [DW-1:0] range_total;
        logic [AW-1:0]        found_pos;
    } lrast_out_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLR,
        DP_FOLD,
        DP_PUSHC,
        DP_ADDW,
        DP_ACC_CLR,
        DP_ACC_ADD,
        DP_WSUM
    } dp_op_t;

    typedef struct packed {
        dp_op_t        op;
        logic [AW-1:0] addr;
        logic [AW-1:0] rd_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic          pend_nz;
        logic          hit;
        logic [DW-1:0] acc;
    } dp_sts_t;

    // index of highest set bit, zero for zero
    function automatic logic [JW-1:0] msb_idx(input logic [AW-1:0] v);
        logic [JW-1:0] r;
        r = '0;
        for (int n = 0; n < AW; n++) begin
            if (v[n]) begin
                r = JW'(n);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/lazy_range_add_range_sum_tree.sv @@
`timescale 1ns / 1ps
// channel   ports                       payload
// request   s_valid s_ready s_payload   lrast_in_t
// result    m_valid m_ready m_payload   lrast_out_t
//
// One request at a time; a node settle reads the node (ST_RD), folds its pending
// add (ST_FOLD) and, when that add is nonzero on an inner node, pushes it to the
// children (ST_C0, ST_C1). An empty or reversed range goes straight to done.
// After reset the RAMs are swept to zero with s_ready low.
// A new request is taken while the previous result waits on m_ready.
module lazy_range_add_range_sum_tree
    import lrast_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lrast_in_t  s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output lrast_out_t m_payload
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    lrast_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

    lrast_dp u_dp (
        .aclk      (aclk),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ rtl/lrast_ram.sv @@
`timescale 1ns / 1ps
module lrast_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/lrast_dp.sv @@
`timescale 1ns / 1ps
module lrast_dp
    import lrast_pkg::*;
(
    input  logic      aclk,
    input  lrast_in_t s_payload,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts
);

    logic [DW-1:0] sum_rd, pend_rd;
    logic          sum_we, pend_we;
    logic [DW-1:0] sum_wd, pend_wd;
    logic [DW-1:0] ns;
    logic [JW-1:0] sh;
    logic [DW-1:0] run_sum;

    logic [DW-1:0] pk_reg, val_reg, acc_reg, w_reg, x_reg;
    logic          strict_reg;

    lrast_ram #(.WIDTH(DW), .DEPTH(2 * LEAVES)) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (sum_we),
        .wr_addr (cmd.addr),
        .wr_data (sum_wd),
        .rd_addr (cmd.rd_addr),
        .rd_data (sum_rd)
    );

    lrast_ram #(.WIDTH(DW), .DEPTH(2 * LEAVES)) u_pend_ram (
        .aclk    (aclk),
        .wr_en   (pend_we),
        .wr_addr (cmd.addr),
        .wr_data (pend_wd),
        .rd_addr (cmd.rd_addr),
        .rd_data (pend_rd)
    );

    // node length is a power of two set by its depth
    assign sh = JW'(LW) - msb_idx(cmd.addr);
    assign ns = sum_rd + (pend_rd << sh);
    assign run_sum = acc_reg + val_reg;

    always_comb begin
        sum_we  = 1'b0;
        pend_we = 1'b0;
        sum_wd  = '0;
        pend_wd = '0;
        case (cmd.op)
            DP_CLR: begin
                sum_we  = 1'b1;
                pend_we = 1'b1;
            end
            DP_FOLD: begin
                sum_we  = 1'b1;
                sum_wd  = ns;
                pend_we = 1'b1;
            end
            DP_PUSHC: begin
                pend_we = 1'b1;
                pend_wd = pend_rd + pk_reg;
            end
            DP_ADDW: begin
                pend_we = 1'b1;
                pend_wd = pend_rd + w_reg;
            end
            DP_WSUM: begin
                sum_we = 1'b1;
                sum_wd = acc_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                w_reg      <= s_payload.add_value;
                x_reg      <= s_payload.threshold;
                strict_reg <= (s_payload.operation == OP_UPPER);
                acc_reg    <= '0;
            end
            DP_FOLD: begin
                pk_reg  <= pend_rd;
                val_reg <= ns;
            end
            DP_ACC_CLR: acc_reg <= '0;
            DP_ACC_ADD: acc_reg <= run_sum;
            default: begin
            end
        endcase
    end

    assign sts.pend_nz = (pend_rd != '0);
    assign sts.hit = strict_reg ? ($signed(run_sum) > $signed(x_reg))
                                : ($signed(run_sum) >= $signed(x_reg));
    assign sts.acc = acc_reg;

endmodule

@@ rtl/lrast_ctrl.sv @@
`timescale 1ns / 1ps
module lrast_ctrl
    import lrast_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lrast_in_t  s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output lrast_out_t m_payload,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts
);

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_DONE,
        ST_RD, ST_FOLD, ST_C0, ST_C1,
        RA_CHK, RA_AW, RA_B, RA_BW, RA_SH,
        CL_A, CL_B, CL_N,
        RC_0, RC_1, RC_2, RC_3,
        RS_P1, RS_P2, RS_LOOP, RS_AA, RS_B, RS_BA, RS_SH,
        SZ, PP_INIT, PP_LOOP, PP_NXT,
        SR_UP, SR_S, SR_H, SR_D, SR_DH
    } state_t;

    state_t        state_reg, state_next;
    state_t        st_ret_reg, st_ret_next;
    state_t        pp_ret_reg, pp_ret_next;
    state_t        rc_ret_reg, rc_ret_next;
    logic [1:0]    op_reg, op_next;
    logic [IW-1:0] a_reg, a_next, b_reg, b_next;
    logic [IW-1:0] a0_reg, a0_next, b0_reg, b0_next;
    logic [IW-1:0] p_reg, p_next, t_reg, t_next;
    logic [AW-1:0] k_reg, k_next;
    logic [LW-1:0] y_reg, y_next;
    logic [JW-1:0] j_reg, j_next, i_reg, i_next;
    logic          first_reg, first_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic          m_valid_reg, m_valid_next;
    lrast_out_t    m_data_reg, m_data_next;

    logic [AW-1:0] l_clamp, r_clamp;
    logic [IW-1:0] lo_mask;
    logic [IW-1:0] p_inc;

    assign l_clamp = (s_payload.range_left > AW'(LEAVES)) ? AW'(LEAVES)
                                                          : s_payload.range_left;
    assign r_clamp = (s_payload.range_right > AW'(LEAVES)) ? AW'(LEAVES)
                                                           : s_payload.range_right;
    assign lo_mask = (IW'(1) << i_reg) - IW'(1);
    assign p_inc   = p_reg + IW'(1);

    always_comb begin
        state_next   = state_reg;
        st_ret_next  = st_ret_reg;
        pp_ret_next  = pp_ret_reg;
        rc_ret_next  = rc_ret_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        a0_next      = a0_reg;
        b0_next      = b0_reg;
        p_next       = p_reg;
        t_next       = t_reg;
        k_next       = k_reg;
        y_next       = y_reg;
        j_next       = j_reg;
        i_next       = i_reg;
        first_next   = first_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        cmd.op       = DP_NOP;
        cmd.addr     = k_reg;
        cmd.rd_addr  = k_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR: begin
                cmd.op = DP_CLR;
                k_next = k_reg + AW'(1);
                if (k_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    op_next    = s_payload.operation;
                    a_next     = IW'(l_clamp) + IW'(LEAVES);
                    b_next     = IW'(r_clamp) + IW'(LEAVES);
                    a0_next    = IW'(l_clamp) + IW'(LEAVES);
                    b0_next    = IW'(r_clamp) + IW'(LEAVES);
                    p_next     = IW'(s_payload.start_pos) + IW'(LEAVES);
                    first_next = 1'b1;
                    pos_next   = '0;
                    unique case (s_payload.operation)
                        OP_ADD: state_next = (l_clamp < r_clamp) ? RA_CHK : S_DONE;
                        OP_SUM: state_next = (l_clamp < r_clamp) ? RS_P1 : S_DONE;
                        default: state_next = SR_UP;
                    endcase
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.range_total = (op_reg == OP_SUM) ? sts.acc : '0;
                    m_data_next.found_pos   = pos_reg;
                    state_next              = S_IDLE;
                end
            end

            // fold one node's pending add, push it to the children
            ST_RD: begin
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.op      = DP_FOLD;
                cmd.rd_addr = {k_reg[AW-2:0], 1'b0};
                if (sts.pend_nz && (k_reg < AW'(LEAVES))) begin
                    state_next = ST_C0;
                end else begin
                    state_next = st_ret_reg;
                end
            end
            ST_C0: begin
                cmd.op      = DP_PUSHC;
                cmd.addr    = {k_reg[AW-2:0], 1'b0};
                cmd.rd_addr = {k_reg[AW-2:0], 1'b1};
                state_next  = ST_C1;
            end
            ST_C1: begin
                cmd.op     = DP_PUSHC;
                cmd.addr   = {k_reg[AW-2:0], 1'b1};
                state_next = st_ret_reg;
            end

            // range add: tag cover nodes
            RA_CHK: begin
                if (a_reg < b_reg) begin
                    if (a_reg[0]) begin
                        cmd.rd_addr = AW'(a_reg);
                        state_next  = RA_AW;
                    end else begin
                        state_next = RA_B;
                    end
                end else begin
                    i_next     = JW'(1);
                    state_next = CL_A;
                end
            end
            RA_AW: begin
                cmd.op     = DP_ADDW;
                cmd.addr   = AW'(a_reg);
                a_next     = a_reg + IW'(1);
                state_next = RA_B;
            end
            RA_B: begin
                if (b_reg[0]) begin
                    b_next      = b_reg - IW'(1);
                    cmd.rd_addr = AW'(b_reg - IW'(1));
                    state_next  = RA_BW;
                end else begin
                    state_next = RA_SH;
                end
            end
            RA_BW: begin
                cmd.op     = DP_ADDW;
                cmd.addr   = AW'(b_reg);
                state_next = RA_SH;
            end
            RA_SH: begin
                a_next     = a_reg >> 1;
                b_next     = b_reg >> 1;
                state_next = RA_CHK;
            end

            // range add: rebuild boundary ancestors
            CL_A: begin
                if (i_reg > JW'(LW)) begin
                    state_next = S_DONE;
                end else if ((a0_reg & lo_mask) != '0) begin
                    y_next      = LW'(a0_reg >> i_reg);
                    rc_ret_next = CL_B;
                    state_next  = RC_0;
                end else begin
                    state_next = CL_B;
                end
            end
            CL_B: begin
                if ((b0_reg & lo_mask) != '0) begin
                    y_next      = LW'((b0_reg - IW'(1)) >> i_reg);
                    rc_ret_next = CL_N;
                    state_next  = RC_0;
                end else begin
                    state_next = CL_N;
                end
            end
            CL_N: begin
                i_next     = i_reg + JW'(1);
                state_next = CL_A;
            end
            RC_0: begin
                cmd.op      = DP_ACC_CLR;
                k_next      = {y_reg, 1'b0};
                st_ret_next = RC_1;
                state_next  = ST_RD;
            end
            RC_1: begin
                cmd.op      = DP_ACC_ADD;
                k_next      = {y_reg, 1'b1};
                st_ret_next = RC_2;
                state_next  = ST_RD;
            end
            RC_2: begin
                cmd.op     = DP_ACC_ADD;
                state_next = RC_3;
            end
            RC_3: begin
                cmd.op     = DP_WSUM;
                cmd.addr   = AW'(y_reg);
                state_next = rc_ret_reg;
            end

            // range sum
            RS_P1: begin
                t_next      = a_reg;
                pp_ret_next = RS_P2;
                state_next  = SZ;
            end
            RS_P2: begin
                t_next      = b_reg;
                pp_ret_next = RS_LOOP;
                state_next  = SZ;
            end
            RS_LOOP: begin
                if (a_reg < b_reg) begin
                    if (a_reg[0]) begin
                        k_next      = AW'(a_reg);
                        st_ret_next = RS_AA;
                        state_next  = ST_RD;
                    end else begin
                        state_next = RS_B;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            RS_AA: begin
                cmd.op     = DP_ACC_ADD;
                a_next     = a_reg + IW'(1);
                state_next = RS_B;
            end
            RS_B: begin
                if (b_reg[0]) begin
                    b_next      = b_reg - IW'(1);
                    k_next      = AW'(b_reg - IW'(1));
                    st_ret_next = RS_BA;
                    state_next  = ST_RD;
                end else begin
                    state_next = RS_SH;
                end
            end
            RS_BA: begin
                cmd.op     = DP_ACC_ADD;
                state_next = RS_SH;
            end
            RS_SH: begin
                a_next     = a_reg >> 1;
                b_next     = b_reg >> 1;
                state_next = RS_LOOP;
            end

            // push pending adds root to parent of the boundary block
            SZ: begin
                if ((t_reg != '0) && !t_reg[0]) begin
                    t_next = t_reg >> 1;
                end else begin
                    t_next     = t_reg >> 1;
                    state_next = PP_INIT;
                end
            end
            PP_INIT: begin
                if (t_reg == '0) begin
                    state_next = pp_ret_reg;
                end else begin
                    j_next     = msb_idx(AW'(t_reg));
                    state_next = PP_LOOP;
                end
            end
            PP_LOOP: begin
                k_next      = AW'(t_reg >> j_reg);
                st_ret_next = PP_NXT;
                state_next  = ST_RD;
            end
            PP_NXT: begin
                if (j_reg == '0) begin
                    state_next = pp_ret_reg;
                end else begin
                    j_next     = j_reg - JW'(1);
                    state_next = PP_LOOP;
                end
            end

            // running-sum search
            SR_UP: begin
                if (!p_reg[0]) begin
                    p_next = p_reg >> 1;
                end else if (first_reg) begin
                    first_next  = 1'b0;
                    t_next      = p_reg >> 1;
                    pp_ret_next = SR_S;
                    state_next  = PP_INIT;
                end else begin
                    state_next = SR_S;
                end
            end
            SR_S: begin
                k_next      = AW'(p_reg);
                st_ret_next = SR_H;
                state_next  = ST_RD;
            end
            SR_H: begin
                if (sts.hit) begin
                    state_next = SR_D;
                end else begin
                    cmd.op = DP_ACC_ADD;
                    p_next = p_inc;
                    if ((p_inc & p_reg) == '0) begin
                        pos_next   = AW'(LEAVES);
                        state_next = S_DONE;
                    end else begin
                        state_next = SR_UP;
                    end
                end
            end
            SR_D: begin
                if (p_reg < IW'(LEAVES)) begin
                    p_next      = p_reg << 1;
                    k_next      = AW'(p_reg << 1);
                    st_ret_next = SR_DH;
                    state_next  = ST_RD;
                end else begin
                    pos_next   = AW'(p_reg - IW'(LEAVES));
                    state_next = S_DONE;
                end
            end
            SR_DH: begin
                if (!sts.hit) begin
                    cmd.op      = DP_ACC_ADD;
                    p_next      = p_inc;
                    k_next      = AW'(p_inc);
                    st_ret_next = SR_D;
                    state_next  = ST_RD;
                end else begin
                    state_next = SR_D;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            st_ret_reg  <= S_IDLE;
            pp_ret_reg  <= S_IDLE;
            rc_ret_reg  <= S_IDLE;
            k_reg       <= '0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            st_ret_reg  <= st_ret_next;
            pp_ret_reg  <= pp_ret_next;
            rc_ret_reg  <= rc_ret_next;
            k_reg       <= k_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        a0_reg     <= a0_next;
        b0_reg     <= b0_next;
        p_reg      <= p_next;
        t_reg      <= t_next;
        y_reg      <= y_next;
        j_reg      <= j_next;
        i_reg      <= i_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    a_child_in_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_C0) |-> (k_reg < AW'(LEAVES)))
        else $error("child push from a leaf");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.found_pos <= AW'(LEAVES)))
        else $error("found_pos out of range");

    a_leaf_add_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RA_AW) |-> (a_reg < b_reg))
        else $error("leaf add outside range");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside done");

endmodule
